/* hw/rtl/chacha_pkg.sv */
// chacha_pkg: shared types and constants for the chacha stream cipher
// no dependencies
`default_nettype none
package chacha_pkg;
  localparam logic [31:0] Sigma0 = 32'h61707865;
  localparam logic [31:0] Sigma1 = 32'h3320646e;
  localparam logic [31:0] Sigma2 = 32'h79622d32;
  localparam logic [31:0] Sigma3 = 32'h6b206574;

  // register byte offsets
  localparam logic [5:0] RegKey0   = 6'h00;
  localparam logic [5:0] RegKey1   = 6'h08;
  localparam logic [5:0] RegKey2   = 6'h10;
  localparam logic [5:0] RegKey3   = 6'h18;
  localparam logic [5:0] RegNonceL = 6'h20;
  localparam logic [5:0] RegNonceH = 6'h28;
  localparam logic [5:0] RegCtr    = 6'h30;
  localparam logic [5:0] RegRounds = 6'h38;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_COL, ST_DIAG, ST_ADD, ST_OUT
  } ctrl_state_e;

  typedef struct packed {
    logic load;     // load initial state
    logic col;      // run column round
    logic diag;     // run diagonal round
    logic add;      // add initial state back
    logic take;     // capture input item
    logic emit;     // produce result into output register
  } dp_cmd_t;

  typedef struct packed {
    logic need_block; // next item starts a new block
  } dp_sts_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
    rotl = (v << s) | (v >> (32 - s));
  endfunction

  // half of a quarter round: first or second add/xor/rotate pair
  function automatic logic [127:0] qr_half(input logic [127:0] abcd, input logic second);
    logic [31:0] a, b, c, d;
    a = abcd[31:0]; b = abcd[63:32]; c = abcd[95:64]; d = abcd[127:96];
    a = a + b; d = d ^ a; d = second ? rotl(d, 8) : rotl(d, 16);
    c = c + d; b = b ^ c; b = second ? rotl(b, 7) : rotl(b, 12);
    qr_half = {d, c, b, a};
  endfunction
endpackage
`default_nettype wire

/* hw/rtl/chacha_if.sv */
// chacha_if: valid/ready stream channel carrying data, byte count and last
// depends on nothing
`default_nettype none
interface chacha_if;
  logic        valid;
  logic        ready;
  logic [63:0] data;
  logic [3:0]  bytes;
  logic        last;
  modport source (output valid, data, bytes, last, input ready);
  modport sink (input valid, data, bytes, last, output ready);
endinterface
`default_nettype wire

/* hw/rtl/chacha_ctrl.sv */
// chacha_ctrl: sequencer for block build and item processing
// depends on chacha_pkg
`default_nettype none
module chacha_ctrl (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  input  wire                   out_free_i,
  input  wire  [4:0]            rounds_i,
  input  chacha_pkg::dp_sts_t   sts_i,
  output logic                  in_ready_o,
  output chacha_pkg::dp_cmd_t   cmd_o
);
  chacha_pkg::ctrl_state_e state_q, state_d;
  logic [3:0] pairs_q, pairs_d;
  logic       half_q, half_d;

  // next state
  always_comb begin
    state_d = state_q;
    pairs_d = pairs_q;
    half_d  = half_q;
    case (state_q)
      chacha_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (sts_i.need_block) state_d = chacha_pkg::ST_LOAD;
          else state_d = chacha_pkg::ST_OUT;
        end
      end
      chacha_pkg::ST_LOAD: begin
        pairs_d = rounds_i[4:1];
        half_d  = 1'b0;
        state_d = (rounds_i[4:1] == 4'd0) ? chacha_pkg::ST_ADD : chacha_pkg::ST_COL;
      end
      chacha_pkg::ST_COL: begin
        half_d = ~half_q;
        if (half_q) state_d = chacha_pkg::ST_DIAG;
      end
      chacha_pkg::ST_DIAG: begin
        half_d = ~half_q;
        if (half_q) begin
          pairs_d = pairs_q - 4'd1;
          state_d = (pairs_q == 4'd1) ? chacha_pkg::ST_ADD : chacha_pkg::ST_COL;
        end
      end
      chacha_pkg::ST_ADD: state_d = chacha_pkg::ST_OUT;
      chacha_pkg::ST_OUT: if (out_free_i) state_d = chacha_pkg::ST_IDLE;
      default: state_d = chacha_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      chacha_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.take   = in_valid_i;
      end
      chacha_pkg::ST_LOAD: cmd_o.load = 1'b1;
      chacha_pkg::ST_COL:  cmd_o.col  = 1'b1;
      chacha_pkg::ST_DIAG: cmd_o.diag = 1'b1;
      chacha_pkg::ST_ADD:  cmd_o.add  = 1'b1;
      chacha_pkg::ST_OUT:  cmd_o.emit = out_free_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= chacha_pkg::ST_IDLE;
      pairs_q <= '0;
      half_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pairs_q <= pairs_d;
      half_q  <= half_d;
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/chacha_dp.sv */
// chacha_dp: keystream state, four quarter-round lanes, xor and output register
// depends on chacha_pkg
`default_nettype none
module chacha_dp #(
  parameter int LANE_BYTES = 8
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  chacha_pkg::dp_cmd_t  cmd_i,
  input  wire  [255:0]         key_i,
  input  wire  [95:0]          nonce_i,
  input  wire  [31:0]          init_ctr_i,
  input  wire  [63:0]          in_data_i,
  input  wire  [3:0]           in_bytes_i,
  input  wire                  in_last_i,
  input  wire                  out_ready_i,
  output logic                 out_valid_o,
  output logic [63:0]          out_data_o,
  output logic [3:0]           out_bytes_o,
  output logic                 out_last_o,
  output logic                 out_free_o,
  output chacha_pkg::dp_sts_t  sts_o
);
  localparam int Lane = (LANE_BYTES < 8) ? LANE_BYTES : 8;
  localparam int ItemsRaw = 64 / LANE_BYTES;
  localparam int Items = (ItemsRaw == 0) ? 1 : ItemsRaw;
  localparam int PosW = (Items > 1) ? $clog2(Items) : 1;

  logic [31:0] x_q [16];
  logic [31:0] ctr_q;
  logic [PosW-1:0] pos_q;
  logic        start_q;
  logic        half_q;
  logic [63:0] din_q;
  logic [3:0]  nb_q;
  logic        last_q;
  logic [31:0] init_w [16];
  logic [31:0] blk_ctr;

  assign blk_ctr = start_q ? init_ctr_i : ctr_q;
  assign sts_o.need_block = (pos_q == '0);
  assign out_free_o = !out_valid_o || out_ready_i;

  // initial state words; counter word is captured at build time
  always_comb begin
    init_w[0] = chacha_pkg::Sigma0; init_w[1] = chacha_pkg::Sigma1;
    init_w[2] = chacha_pkg::Sigma2; init_w[3] = chacha_pkg::Sigma3;
    for (int i = 0; i < 8; i++) init_w[4+i] = key_i[32*i +: 32];
    init_w[12] = ctr_q;
    for (int i = 0; i < 3; i++) init_w[13+i] = nonce_i[32*i +: 32];
  end

  // quarter-round lanes
  logic [127:0] lane_in [4];
  logic [127:0] lane_out [4];
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      if (cmd_i.diag)
        lane_in[l] = {x_q[12 + ((l + 3) % 4)], x_q[8 + ((l + 2) % 4)],
                      x_q[4 + ((l + 1) % 4)], x_q[l]};
      else
        lane_in[l] = {x_q[12+l], x_q[8+l], x_q[4+l], x_q[l]};
      lane_out[l] = chacha_pkg::qr_half(lane_in[l], half_q);
    end
  end

  // keystream lane for current position
  logic [63:0] ks;
  logic [63:0] res;
  logic [3:0]  cnt;
  always_comb begin
    logic [5:0] b;
    ks = '0;
    for (int k = 0; k < 8; k++) begin
      b = 6'((int'(pos_q) * LANE_BYTES + k) & 63);
      ks[8*k +: 8] = x_q[b[5:2]][8*b[1:0] +: 8];
    end
    cnt = (nb_q < 4'(Lane)) ? nb_q : 4'(Lane);
    res = '0;
    for (int k = 0; k < 8; k++)
      if (4'(k) < cnt) res[8*k +: 8] = din_q[8*k +: 8] ^ ks[8*k +: 8];
  end

  // state register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int i = 0; i < 16; i++) x_q[i] <= init_w[i];
    end else if (cmd_i.col || cmd_i.diag) begin
      for (int l = 0; l < 4; l++) begin
        if (cmd_i.diag) begin
          x_q[l]                <= lane_out[l][31:0];
          x_q[4 + ((l+1) % 4)]  <= lane_out[l][63:32];
          x_q[8 + ((l+2) % 4)]  <= lane_out[l][95:64];
          x_q[12 + ((l+3) % 4)] <= lane_out[l][127:96];
        end else begin
          x_q[l]    <= lane_out[l][31:0];
          x_q[4+l]  <= lane_out[l][63:32];
          x_q[8+l]  <= lane_out[l][95:64];
          x_q[12+l] <= lane_out[l][127:96];
        end
      end
    end else if (cmd_i.add) begin
      for (int i = 0; i < 16; i++) x_q[i] <= x_q[i] + init_w[i];
    end
    if (cmd_i.take) begin
      din_q  <= in_data_i;
      nb_q   <= in_bytes_i;
      last_q <= in_last_i;
    end
    if (cmd_i.emit) begin
      out_data_o  <= res;
      out_bytes_o <= nb_q;
      out_last_o  <= last_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q       <= '0;
      pos_q       <= '0;
      start_q     <= 1'b1;
      half_q      <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (cmd_i.take && pos_q == '0) begin
        ctr_q   <= blk_ctr;
        start_q <= 1'b0;
      end
      if (cmd_i.add) ctr_q <= ctr_q + 32'd1;
      if (cmd_i.load) half_q <= 1'b0;
      else if (cmd_i.col || cmd_i.diag) half_q <= ~half_q;
      if (cmd_i.emit) begin
        if (last_q) begin
          pos_q   <= '0;
          start_q <= 1'b1;
        end else if (32'(pos_q) == Items - 1) pos_q <= '0;
        else pos_q <= pos_q + PosW'(1);
        out_valid_o <= 1'b1;
      end else if (out_ready_i) out_valid_o <= 1'b0;
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/chacha_stream_cipher.sv */
// chacha_stream_cipher: top level, apb register file, controller and datapath
// depends on chacha_pkg, chacha_if, chacha_ctrl, chacha_dp
//
// Usage: message items enter on in_ch (64-bit data, byte count, last flag) and
// results leave on out_ch, one per item, in order. Registers (key, nonce,
// initial counter, round count) sit on an apb port at 8-byte strides; the user
// must write them only while the block is idle, as the block does not enforce it.
// An item that starts a 64-byte block goes through load, rounds/2 double rounds
// (rounded down; each a column round and a diagonal round, done in halves through
// four quarter-round lanes), add and output before its result reaches the output
// register; other items go straight from being taken to the output step.
// One item is in work at a time; the output register holds a result while
// the receiver stalls, and the controller waits in its output step until the
// register frees. Reset clears control state, restores 20 rounds and zero
// registers; the next message starts at the initial counter.
`default_nettype none
module chacha_stream_cipher #(
  parameter int LANE_BYTES = 8
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  chacha_if.sink      in_ch,
  chacha_if.source    out_ch,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [5:0]  paddr,
  input  wire  [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  logic [63:0] key0_q, key1_q, key2_q, key3_q, nonl_q;
  logic [31:0] nonh_q, ctr0_q;
  logic [4:0]  rounds_q;
  logic        wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  // register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key0_q <= '0; key1_q <= '0; key2_q <= '0; key3_q <= '0;
      nonl_q <= '0; nonh_q <= '0; ctr0_q <= '0; rounds_q <= 5'd20;
    end else if (wr) begin
      case (paddr)
        chacha_pkg::RegKey0:   key0_q <= pwdata;
        chacha_pkg::RegKey1:   key1_q <= pwdata;
        chacha_pkg::RegKey2:   key2_q <= pwdata;
        chacha_pkg::RegKey3:   key3_q <= pwdata;
        chacha_pkg::RegNonceL: nonl_q <= pwdata;
        chacha_pkg::RegNonceH: nonh_q <= pwdata[31:0];
        chacha_pkg::RegCtr:    ctr0_q <= pwdata[31:0];
        chacha_pkg::RegRounds: rounds_q <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (paddr)
      chacha_pkg::RegKey0:   prdata = key0_q;
      chacha_pkg::RegKey1:   prdata = key1_q;
      chacha_pkg::RegKey2:   prdata = key2_q;
      chacha_pkg::RegKey3:   prdata = key3_q;
      chacha_pkg::RegNonceL: prdata = nonl_q;
      chacha_pkg::RegNonceH: prdata = {32'd0, nonh_q};
      chacha_pkg::RegCtr:    prdata = {32'd0, ctr0_q};
      chacha_pkg::RegRounds: prdata = {59'd0, rounds_q};
      default:               prdata = '0;
    endcase
  end

  chacha_pkg::dp_cmd_t cmd;
  chacha_pkg::dp_sts_t sts;
  logic out_free;

  chacha_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_ch.valid), .out_free_i(out_free), .rounds_i(rounds_q),
    .sts_i(sts), .in_ready_o(in_ch.ready), .cmd_o(cmd)
  );

  chacha_dp #(.LANE_BYTES(LANE_BYTES)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd),
    .key_i({key3_q, key2_q, key1_q, key0_q}), .nonce_i({nonh_q, nonl_q}),
    .init_ctr_i(ctr0_q),
    .in_data_i(in_ch.data), .in_bytes_i(in_ch.bytes), .in_last_i(in_ch.last),
    .out_ready_i(out_ch.ready), .out_valid_o(out_ch.valid),
    .out_data_o(out_ch.data), .out_bytes_o(out_ch.bytes), .out_last_o(out_ch.last),
    .out_free_o(out_free), .sts_o(sts)
  );
endmodule
`default_nettype wire

/* hw/rtl/chacha_checker.sv */
// chacha_checker: port-level assertions for chacha_stream_cipher, with bind
// depends on chacha_if
`default_nettype none
module chacha_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [63:0] out_data,
  input wire [3:0]  out_bytes,
  input wire        out_last
);
  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data) && $stable(out_last))
    else $error("result changed while stalled");
  // one item at a time: no new request right after one is taken
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken back to back");
  // a zero byte count yields zero data
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_bytes == 4'd0 |-> out_data == 64'd0)
    else $error("data on empty result");
  // no result straight out of reset
  a_rst: assert property (@(posedge clk_i) !rst_ni |=> !out_valid)
    else $error("result after reset");
endmodule

bind chacha_stream_cipher chacha_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_data(out_ch.data), .out_bytes(out_ch.bytes), .out_last(out_ch.last)
);
`default_nettype wire

/* test/testbench.sv */
// testbench: checks chacha_stream_cipher against a behavioral keystream predictor
// depends on chacha_pkg, chacha_if and the chacha_stream_cipher rtl
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 20000;

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [5:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  chacha_if in_ch ();
  chacha_if out_ch ();

  chacha_stream_cipher dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  bytes;
    logic        last;
  } cipher_item_t;

  // predictor copy of registers and state
  logic [63:0] key_q [4];
  logic [63:0] nonce_lo_q;
  logic [31:0] nonce_hi_q, init_ctr_q;
  logic [4:0]  rounds_q;
  logic [31:0] ks_words [16];
  logic [31:0] blk_ctr;
  logic [2:0]  lane_pos;
  logic        msg_start;

  cipher_item_t cipher_fifo[$];
  int  errors;
  int  idle_cycles;
  bit  stall_free;
  bit  stim_done;

  // clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [31:0] rol32(logic [31:0] v, int s);
    return (v << s) | (v >> (32 - s));
  endfunction

  // one quarter round on four state words
  task automatic mix_quarter(inout logic [31:0] x [16], input int a, b, c, d);
    x[a] = x[a] + x[b]; x[d] = rol32(x[d] ^ x[a], 16);
    x[c] = x[c] + x[d]; x[b] = rol32(x[b] ^ x[c], 12);
    x[a] = x[a] + x[b]; x[d] = rol32(x[d] ^ x[a], 8);
    x[c] = x[c] + x[d]; x[b] = rol32(x[b] ^ x[c], 7);
  endtask

  task automatic make_keystream();
    logic [31:0] seed [16];
    logic [31:0] x [16];
    seed[0] = chacha_pkg::Sigma0; seed[1] = chacha_pkg::Sigma1;
    seed[2] = chacha_pkg::Sigma2; seed[3] = chacha_pkg::Sigma3;
    for (int i = 0; i < 4; i++) begin
      seed[4 + 2*i] = key_q[i][31:0];
      seed[5 + 2*i] = key_q[i][63:32];
    end
    seed[12] = blk_ctr;
    seed[13] = nonce_lo_q[31:0];
    seed[14] = nonce_lo_q[63:32];
    seed[15] = nonce_hi_q;
    x = seed;
    for (int p = 0; p < rounds_q / 2; p++) begin
      mix_quarter(x, 0, 4, 8, 12);  mix_quarter(x, 1, 5, 9, 13);
      mix_quarter(x, 2, 6, 10, 14); mix_quarter(x, 3, 7, 11, 15);
      mix_quarter(x, 0, 5, 10, 15); mix_quarter(x, 1, 6, 11, 12);
      mix_quarter(x, 2, 7, 8, 13);  mix_quarter(x, 3, 4, 9, 14);
    end
    for (int i = 0; i < 16; i++) ks_words[i] = x[i] + seed[i];
  endtask

  // predicts the ciphertext of one request
  task automatic encrypt_item(input cipher_item_t req, output cipher_item_t res);
    int n;
    int b;
    n = (req.bytes > 8) ? 8 : int'(req.bytes);
    if (lane_pos == 0) begin
      if (msg_start) begin
        blk_ctr = init_ctr_q;
        msg_start = 1'b0;
      end
      make_keystream();
      blk_ctr = blk_ctr + 1;
    end
    res = '0;
    res.bytes = req.bytes;
    res.last = req.last;
    for (int k = 0; k < n; k++) begin
      b = lane_pos * 8 + k;
      res.data[k*8 +: 8] = req.data[k*8 +: 8] ^ ks_words[b / 4][(b % 4) * 8 +: 8];
    end
    lane_pos = lane_pos + 1;
    if (req.last) begin
      lane_pos = 0;
      msg_start = 1'b1;
    end
  endtask

  // register write over apb, predictor updated alongside
  task automatic write_reg(input int idx, input logic [63:0] val);
    @(negedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 6'(idx * 8); pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      0, 1, 2, 3: key_q[idx] = val;
      4: nonce_lo_q = val;
      5: nonce_hi_q = val[31:0];
      6: init_ctr_q = val[31:0];
      7: rounds_q = val[4:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // drive one request, idling at random; valid stays up for a following request
  task automatic send_item(input cipher_item_t req);
    cipher_item_t res;
    while (!stall_free && $urandom_range(99) < 20) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= req.data;
    in_ch.bytes <= req.bytes;
    in_ch.last <= req.last;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    encrypt_item(req, res);
    cipher_fifo.push_back(res);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (cipher_fifo.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  task automatic random_config(input bit extreme);
    for (int i = 0; i < 7; i++)
      write_reg(i, extreme ? {64{$urandom_range(1)}} != 0 ? '1 : '0
                           : {$urandom, $urandom});
    write_reg(7, 64'(extreme ? ($urandom_range(1) ? 20 : 2) : 2 * $urandom_range(1, 10)));
  endtask

  // output side: random stall and compare against oldest prediction
  always @(negedge clk_i) begin
    if (!rst_ni) out_ch.ready <= 1'b0;
    else out_ch.ready <= stall_free || ($urandom_range(99) >= 20);
  end

  always @(posedge clk_i) begin
    cipher_item_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (cipher_fifo.size() == 0) begin
        $display("%0t unexpected result data=%h bytes=%0d last=%b", $time,
                 out_ch.data, out_ch.bytes, out_ch.last);
        errors++;
      end else begin
        want = cipher_fifo.pop_front();
        if (out_ch.data !== want.data || out_ch.bytes !== want.bytes
            || out_ch.last !== want.last) begin
          $display({"%0t mismatch expected data=%h bytes=%0d last=%b",
                    " actual data=%h bytes=%0d last=%b"},
                   $time, want.data, want.bytes, want.last,
                   out_ch.data, out_ch.bytes, out_ch.last);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted request, result or register access
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit && !stim_done) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // directed rows: zero key at 20 rounds gives the well-known first keystream
  // bytes 76 b8 e0 ad a0 f1 3d 90 for counter zero and zero nonce
  cipher_item_t directed [20];
  logic [63:0]  directed_want [20];
  bit           directed_known [20];

  initial begin
    cipher_item_t req;
    cipher_item_t res;
    int rounds_set [4] = '{2, 20, 12, 8};
    errors = 0; idle_cycles = 0; stall_free = 1'b0; stim_done = 1'b0;
    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_ch.valid = 1'b0; in_ch.data = '0; in_ch.bytes = '0; in_ch.last = 1'b0;
    out_ch.ready = 1'b0;
    for (int i = 0; i < 4; i++) key_q[i] = '0;
    nonce_lo_q = '0; nonce_hi_q = '0; init_ctr_q = '0; rounds_q = 5'd20;
    blk_ctr = '0; lane_pos = '0; msg_start = 1'b1;
    foreach (ks_words[i]) ks_words[i] = '0;

    // table: zero data reveals keystream, then extremes, short and odd counts
    for (int i = 0; i < 20; i++) begin
      directed[i] = '{data: '0, bytes: 4'd8, last: 1'b0};
      directed_known[i] = 1'b0;
    end
    directed_known[0] = 1'b1; directed_want[0] = 64'h903df1a0ade0b876;
    directed[1].data = '1;
    directed[2].bytes = 4'd1; directed[2].data = '1;
    directed[3].bytes = 4'd0; directed[3].data = '1;
    directed_known[3] = 1'b1; directed_want[3] = '0;
    directed[4].bytes = 4'd15; directed[4].data = 64'h0123456789abcdef;
    directed[5].bytes = 4'd9;
    directed[6].bytes = 4'd3; directed[6].last = 1'b1;
    directed[7].last = 1'b1;
    for (int i = 8; i < 20; i++) directed[i].data = {$urandom, $urandom};
    directed[19].last = 1'b1;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < 20; i++) begin
      send_item(directed[i]);
      if (directed_known[i] && cipher_fifo[$].data !== directed_want[i]) begin
        $display("%0t directed row %0d expected %h predicted %h", $time, i,
                 directed_want[i], cipher_fifo[$].data);
        errors++;
      end
    end
    drain();

    // special settings: odd, zero and maximum round counts, counter wrap
    write_reg(7, 64'd0);
    write_reg(6, 64'hffff_ffff);
    for (int i = 0; i < 20; i++) begin
      req = '{data: {$urandom, $urandom}, bytes: 4'd8, last: (i == 19)};
      send_item(req);
    end
    drain();
    write_reg(7, 64'd31);
    write_reg(7, 64'd1);
    send_item('{data: '1, bytes: 4'd8, last: 1'b1});
    drain();

    // random phases with changing settings, long stall-free stretch in one
    for (int ph = 0; ph < 8; ph++) begin
      random_config(ph == 1 || ph == 6);
      if (ph >= 4) write_reg(7, 64'(rounds_set[ph - 4]));
      stall_free = (ph == 3);
      for (int i = 0; i < 200; i++) begin
        req.data = {$urandom, $urandom};
        req.last = ($urandom_range(99) < 8) || (i == 199);
        req.bytes = req.last ? 4'($urandom_range(1, 8)) : 4'd8;
        if ($urandom_range(99) < 5) req.bytes = 4'($urandom_range(0, 15));
        send_item(req);
        // mid-message writes take effect at the next block
        if (ph == 5 && i == 50) begin
          drain();
          write_reg(0, {$urandom, $urandom});
        end
      end
      drain();
    end
    stall_free = 1'b0;
    stim_done = 1'b1;

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* sim.f */
hw/rtl/chacha_pkg.sv
hw/rtl/chacha_if.sv
hw/rtl/chacha_ctrl.sv
hw/rtl/chacha_dp.sv
hw/rtl/chacha_stream_cipher.sv
hw/rtl/chacha_checker.sv
test/testbench.sv
